FILE: rtl/genotype_weighted_row_accumulator_unit_assert.svh
// Assertion macros used by the accumulator RTL.
`ifndef GENOTYPE_WEIGHTED_ROW_ACCUMULATOR_UNIT_ASSERT_SVH
`define GENOTYPE_WEIGHTED_ROW_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication under asynchronous active-low reset.
`define GWRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gwra: same-cycle implication failed");

// Next-cycle implication under asynchronous active-low reset.
`define GWRA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gwra: next-cycle implication failed");

`endif

FILE: rtl/gwra_pkg.sv
// ----------------------------------------------------------------------------
// gwra_pkg
// Types and constants of the genotype-weighted row accumulator.
// ----------------------------------------------------------------------------
package gwra_pkg;

  localparam int unsigned GWRA_ROWS_DEFAULT = 1024;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned EXT_W = SUM_W + 2;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  localparam logic [1:0] GENO_ONE = 2'd1;
  localparam logic [1:0] GENO_TWO = 2'd2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    opcode_e            opcode;
    logic [9:0]         row;
    logic signed [31:0] element;
    logic [1:0]         genotype;
  } item_t;

  typedef struct packed {
    logic [9:0]              row_index;
    logic signed [SUM_W-1:0] row_sum;
    logic                    saturated;
  } result_t;

  typedef struct packed {
    logic                    sat;
    logic signed [SUM_W-1:0] sum;
  } entry_t;

endpackage

FILE: rtl/gwra_row_mem.sv
// ----------------------------------------------------------------------------
// gwra_row_mem
// Row accumulator memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gwra_row_mem #(
  parameter int unsigned ROWS = gwra_pkg::GWRA_ROWS_DEFAULT,
  localparam int unsigned AddrW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  gwra_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output gwra_pkg::entry_t rdata_o
);
  import gwra_pkg::*;

  entry_t mem_q [ROWS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gwra_clear.sv
// ----------------------------------------------------------------------------
// gwra_clear
// Sweeps every memory row once after reset so that all sums start at zero.
// ----------------------------------------------------------------------------
module gwra_clear #(
  parameter int unsigned ROWS = gwra_pkg::GWRA_ROWS_DEFAULT,
  localparam int unsigned AddrW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             active_o,
  output logic [AddrW-1:0] addr_o
);
  import gwra_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(ROWS - 1);

  logic             active_d, active_q;
  logic [AddrW-1:0] cnt_d, cnt_q;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (active_q) begin
      if (cnt_q == LastAddr) begin
        active_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  assign active_o = active_q;
  assign addr_o   = cnt_q;

endmodule

FILE: rtl/genotype_weighted_row_accumulator_unit.sv
// ----------------------------------------------------------------------------
// genotype_weighted_row_accumulator_unit
// Accumulates matrix elements weighted by genotype 0, 1 or 2 into row sums.
// ----------------------------------------------------------------------------
// Usage: an item transfers on a rising edge with start high and busy low.
// An accumulate item adds element times its genotype weight into the row's
// saturating 48-bit sum; genotype code three adds nothing. A read item
// returns the row's sum and saturation mark and clears both. Rows at or
// beyond ROWS are ignored by accumulate and read back as zero.
// One item is taken every cycle while busy is low. An item reads the row
// memory in its transfer cycle and writes back in the next cycle; a
// following item on the same row takes the written value from a forwarding
// register. A read result appears on result_o with done_o high for exactly
// one cycle, registered after the read item's s1 stage. The receiver cannot
// stall, so every strobed result must be taken in that cycle.
// After reset a clearing pass writes zero to every row, one row per cycle;
// busy stays high during that pass and low afterward.
// ----------------------------------------------------------------------------
module genotype_weighted_row_accumulator_unit #(
  parameter int unsigned ROWS = gwra_pkg::GWRA_ROWS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gwra_pkg::item_t   item_i,
  output logic              done_o,
  output gwra_pkg::result_t result_o
);
  import gwra_pkg::*;
  `include "genotype_weighted_row_accumulator_unit_assert.svh"

  localparam int unsigned AddrW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic             clr_active;
  logic [AddrW-1:0] clr_addr;
  logic             accept;

  logic             s1_valid_q;
  item_t            s1_item_q;
  logic             s1_in_range_q;
  logic [AddrW-1:0] s1_addr;

  entry_t           rdata;
  entry_t           old_entry;
  entry_t           new_entry;
  logic             fwd_hit;
  logic             fwd_valid_q;
  logic [AddrW-1:0] fwd_addr_q;
  entry_t           fwd_data_q;

  logic signed [EXT_W-1:0] addend;
  logic signed [EXT_W-1:0] sum_ext;
  logic                    overflow;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  entry_t           mem_wdata;

  logic    done_q;
  result_t result_q;

  gwra_clear #(.ROWS(ROWS)) u_clear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .active_o(clr_active),
    .addr_o  (clr_addr)
  );

  assign busy   = clr_active;
  assign accept = start & ~clr_active;

  gwra_row_mem #(.ROWS(ROWS)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (accept),
    .raddr_i(AddrW'(item_i.row)),
    .rdata_o(rdata)
  );

  assign s1_addr   = AddrW'(s1_item_q.row);
  assign fwd_hit   = fwd_valid_q && (fwd_addr_q == s1_addr);
  assign old_entry = fwd_hit ? fwd_data_q : rdata;

  always_comb begin
    case (s1_item_q.genotype)
      GENO_ONE: addend = {{(EXT_W-32){s1_item_q.element[31]}}, s1_item_q.element};
      GENO_TWO: addend = {{(EXT_W-33){s1_item_q.element[31]}}, s1_item_q.element, 1'b0};
      default:  addend = '0;
    endcase
    sum_ext  = {{2{old_entry.sum[SUM_W-1]}}, old_entry.sum} + addend;
    overflow = (sum_ext[EXT_W-1:SUM_W-1] != {3{1'b0}}) &&
               (sum_ext[EXT_W-1:SUM_W-1] != {3{1'b1}});
    new_entry = '0;
    if (s1_item_q.opcode == OP_ACCUM) begin
      new_entry.sat = old_entry.sat | overflow;
      if (overflow) begin
        new_entry.sum = sum_ext[EXT_W-1] ? SUM_MIN : SUM_MAX;
      end else begin
        new_entry.sum = sum_ext[SUM_W-1:0];
      end
    end
  end

  assign mem_we    = clr_active | (s1_valid_q & s1_in_range_q);
  assign mem_waddr = clr_active ? clr_addr : s1_addr;
  assign mem_wdata = clr_active ? entry_t'('0) : new_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      fwd_valid_q <= s1_valid_q & s1_in_range_q;
      done_q      <= s1_valid_q && (s1_item_q.opcode == OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q     <= item_i;
      s1_in_range_q <= 32'(item_i.row) < ROWS;
    end
    fwd_addr_q         <= s1_addr;
    fwd_data_q         <= new_entry;
    result_q.row_index <= s1_item_q.row;
    result_q.row_sum   <= s1_in_range_q ? old_entry.sum : '0;
    result_q.saturated <= s1_in_range_q & old_entry.sat;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `GWRA_ASSERT_IMP(a_no_item_in_clear, clk_i, rst_ni, clr_active, !s1_valid_q)
  `GWRA_ASSERT_NXT(a_read_gives_result, clk_i, rst_ni, s1_valid_q && (s1_item_q.opcode == OP_READ), done_q)
  `GWRA_ASSERT_IMP(a_sat_row_in_range, clk_i, rst_ni, done_q && result_q.saturated, 32'(result_q.row_index) < ROWS)
  `GWRA_ASSERT_IMP(a_fwd_after_write, clk_i, rst_ni, fwd_valid_q, $past(s1_valid_q && s1_in_range_q && !clr_active))

endmodule
